// File: rtl/mtg_pkg.sv
// ----------------------------------------------------------------------------
// mtg_pkg
// types, constants and word functions of the mersenne twister generator
// ----------------------------------------------------------------------------
`default_nettype none

package mtg_pkg;

	localparam int STATE_WORDS  = 624;
	localparam int TWIST_OFFSET = 397;
	localparam int IDX_W        = $clog2(STATE_WORDS + 1);
	localparam int WORD_W       = 32;
	localparam int FAR_WRAP     = STATE_WORDS - TWIST_OFFSET;

	localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_B0DF;
	localparam logic [WORD_W-1:0] UPPER_BIT    = 32'h8000_0000;
	localparam logic [WORD_W-1:0] LOWER_BITS   = 32'h7FFF_FFFF;
	localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9D2C_5680;
	localparam logic [WORD_W-1:0] TEMPER_C     = 32'hEFC6_0000;

	localparam logic [IDX_W-1:0] LAST_WORD = IDX_W'(STATE_WORDS - 1);
	localparam logic [IDX_W-1:0] POS_END   = IDX_W'(STATE_WORDS);

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_DRAW   = 2'd1,
		OP_SETPOS = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TW_PRIME,
		ST_TW_LOAD,
		ST_TW_READ,
		ST_TW_CALC,
		ST_DRAW_RD,
		ST_DRAW_TMP
	} state_t;

	function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] i);
		return (i == LAST_WORD) ? '0 : IDX_W'(i + 1'b1);
	endfunction

	function automatic logic [IDX_W-1:0] far_index(input logic [IDX_W-1:0] i);
		return (i < IDX_W'(FAR_WRAP)) ? IDX_W'(i + IDX_W'(TWIST_OFFSET))
			: IDX_W'(i - IDX_W'(FAR_WRAP));
	endfunction

	function automatic logic [WORD_W-1:0] twist_word(
		input logic [WORD_W-1:0] cur,
		input logic [WORD_W-1:0] nxt,
		input logic [WORD_W-1:0] far
	);
		logic [WORD_W-1:0] y;
		logic [WORD_W-1:0] v;
		y = (cur & UPPER_BIT) | (nxt & LOWER_BITS);
		v = far ^ (y >> 1);
		if (y[0]) begin
			v = v ^ TWIST_MATRIX;
		end
		return v;
	endfunction

	function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
		logic [WORD_W-1:0] x;
		x = w ^ (w >> 11);
		x = x ^ ((x << 7) & TEMPER_B);
		x = x ^ ((x << 15) & TEMPER_C);
		x = x ^ (x >> 18);
		return x;
	endfunction

endpackage

`default_nettype wire

// File: rtl/mersenne_twister_generator.sv
// ----------------------------------------------------------------------------
// mersenne_twister_generator
// 32-bit mt19937 generator with a 624-word state memory and one twist unit
// ----------------------------------------------------------------------------
// Software loads the 624 state words with load beats, may move the read
// position with set-position beats, and takes one tempered word per draw
// beat. A draw accepts the beat, reads the memory and tempers the word
// into the output register, waiting while an earlier result is untaken.
// When the read position has reached 624 a draw first regenerates the
// whole state: one twist unit walks the memory word by word, with a read
// state and a calculate state per word for its two registered read ports.
// Loads and set-position beats are taken while a result still waits on
// the output.
`default_nettype none

module mersenne_twister_generator (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [1:0]                  opcode,
	input  wire logic [mtg_pkg::IDX_W-1:0]   word_index,
	input  wire logic [mtg_pkg::WORD_W-1:0]  word_value,
	input  wire logic [mtg_pkg::IDX_W-1:0]   new_position,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [mtg_pkg::WORD_W-1:0]       random_word
);
	import mtg_pkg::*;

	state_t              state_q;
	state_t              state_d;
	logic [IDX_W-1:0]    pos_q;
	logic [IDX_W-1:0]    idx_q;
	logic [WORD_W-1:0]   cur_q;
	logic [WORD_W-1:0]   out_word_q;
	logic                out_valid_q;
	logic                in_beat;
	logic                emit;

	logic [WORD_W-1:0]   mem [STATE_WORDS];
	logic                mem_we;
	logic [IDX_W-1:0]    mem_waddr;
	logic [WORD_W-1:0]   mem_wdata;
	logic [IDX_W-1:0]    addr_a;
	logic [IDX_W-1:0]    addr_b;
	logic [WORD_W-1:0]   rd_a_q;
	logic [WORD_W-1:0]   rd_b_q;

	assign in_ready    = (state_q == ST_IDLE);
	assign in_beat     = in_valid && in_ready;
	assign emit        = (state_q == ST_DRAW_TMP) && (!out_valid_q || out_ready);
	assign out_valid   = out_valid_q;
	assign random_word = out_word_q;

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = twist_word(cur_q, rd_a_q, rd_b_q);
		addr_a    = '0;
		addr_b    = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_beat) begin
					case (opcode)
						OP_LOAD: begin
							if (word_index < POS_END) begin
								mem_we    = 1'b1;
								mem_waddr = word_index;
								mem_wdata = word_value;
							end
						end
						OP_DRAW: begin
							state_d = (pos_q >= POS_END) ? ST_TW_PRIME : ST_DRAW_RD;
						end
						default: begin
						end
					endcase
				end
			end
			ST_TW_PRIME: begin
				addr_a  = '0;
				state_d = ST_TW_LOAD;
			end
			ST_TW_LOAD: begin
				state_d = ST_TW_READ;
			end
			ST_TW_READ: begin
				addr_a  = next_index(idx_q);
				addr_b  = far_index(idx_q);
				state_d = ST_TW_CALC;
			end
			ST_TW_CALC: begin
				mem_we  = 1'b1;
				state_d = (idx_q == LAST_WORD) ? ST_DRAW_RD : ST_TW_READ;
			end
			ST_DRAW_RD: begin
				addr_a  = pos_q;
				state_d = ST_DRAW_TMP;
			end
			ST_DRAW_TMP: begin
				addr_a = pos_q;
				if (emit) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= POS_END;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_beat && opcode == OP_SETPOS) begin
						pos_q <= (new_position > POS_END) ? POS_END : new_position;
					end
				end
				ST_TW_PRIME: begin
					idx_q <= '0;
				end
				ST_TW_CALC: begin
					idx_q <= next_index(idx_q);
					if (idx_q == LAST_WORD) begin
						pos_q <= '0;
					end
				end
				ST_DRAW_TMP: begin
					if (emit) begin
						pos_q <= IDX_W'(pos_q + 1'b1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// twist carry and output word
	always_ff @(posedge clk) begin
		if (state_q == ST_TW_LOAD || state_q == ST_TW_CALC) begin
			cur_q <= rd_a_q;
		end
		if (emit) begin
			out_word_q <= temper(rd_a_q);
		end
	end

	// state memory, one write and two registered reads
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_a_q <= mem[addr_a];
		rd_b_q <= mem[addr_b];
	end

	assert property (@(posedge clk) disable iff (!arst_n) pos_q <= POS_END)
		else $error("read position beyond state size");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAW_RD || state_q == ST_DRAW_TMP) |-> pos_q < POS_END)
		else $error("draw reads outside the state");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TW_CALC && idx_q == LAST_WORD)
		|=> (state_q == ST_DRAW_RD && pos_q == '0 && idx_q == '0))
		else $error("twist did not hand over to the draw at position zero");

	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_IDLE || state_q == ST_TW_CALC))
		else $error("state memory written outside load or twist");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAW_TMP && out_valid_q && !out_ready) |=> state_q == ST_DRAW_TMP)
		else $error("draw result dropped while output stalled");

endmodule

`default_nettype wire
